/* rtl/tterm_pkg.sv */
// ----------------------------------------------------------------------------
// tterm_pkg: shared constants of the text terminal writer
// Request codes, character codes, field widths and register map.
// ----------------------------------------------------------------------------
package tterm_pkg;

    // Default screen geometry.
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Field widths of the stream words.
    localparam int REQ_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int RCOL_W  = 7;
    localparam int RROW_W  = 5;
    localparam int CELL_W  = CHAR_W + ATTR_W;
    localparam int TDATA_W = 32;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // Character codes with a meaning of their own.
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    // Configuration register map.
    localparam int                 PADDR_W         = 3;
    localparam int                 PDATA_W         = 32;
    localparam logic [PADDR_W-1:0] ADDR_FILL_ATTR  = 3'd0;
    localparam logic [ATTR_W-1:0]  FILL_ATTR_RESET = 8'h07;

endpackage

/* rtl/tterm_ram.sv */
// ----------------------------------------------------------------------------
// tterm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered and held when idle.
// ----------------------------------------------------------------------------
module tterm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/text_terminal_writer.sv */
// ----------------------------------------------------------------------------
// text_terminal_writer: character-cell text terminal with scrolling
// A COLUMNS x ROWS screen store of character/attribute cells held in one
// RAM, with a cursor, newline and backspace handling, scroll and clear.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Contents
//  s_        in         tvalid/tready      tuser: req_type; tdata: request word
//  m_        out        tvalid/tready      tdata: result word
//  APB       in/out     psel/penable       fill_attr register at byte address 0
//
// A character write, a read or an unused request is accepted, then carried out
// in the execute state on the screen RAM. A clear writes one blank cell per
// cycle over the whole screen. A write that scrolls adds row copying and the
// blanking of the bottom row, all through the single write port of the RAM.
// After reset all COLUMNS*ROWS cells (2000 by default) are blanked before the
// first word is taken; configuration writes are taken meanwhile.
// A result waiting on m_ does not stop the next word being accepted; the
// block only holds back once a further result is ready and the output is full.
//
module text_terminal_writer #(
    parameter int COLUMNS = tterm_pkg::COLUMNS_DEF,
    parameter int ROWS    = tterm_pkg::ROWS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request words.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata from bit 0: char_code[7:0], char_attr[15:8], read_col[22:16],
    // read_row[27:23], zero padding[31:28].
    input  logic [tterm_pkg::TDATA_W-1:0]  s_tdata,
    // tuser from bit 0: req_type[1:0].
    input  logic [tterm_pkg::REQ_W-1:0]    s_tuser,
    // Result words.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata from bit 0: cell_char[7:0], cell_attr[15:8], cursor_col[22:16],
    // cursor_row[27:23], scrolled[28], zero padding[31:29].
    output logic [tterm_pkg::TDATA_W-1:0]  m_tdata,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tterm_pkg::PADDR_W-1:0]  paddr,
    input  logic [tterm_pkg::PDATA_W-1:0]  pwdata,
    output logic [tterm_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);

    import tterm_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COPY_N = COLUMNS * (ROWS - 1);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_SCROLL = 3'd2;
    localparam logic [2:0] ST_BLANK  = 3'd3;
    localparam logic [2:0] ST_RESP   = 3'd4;

    // Control state.
    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              init_reg, init_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              scr_reg, scr_next;
    logic [ATTR_W-1:0] blank_attr_reg, blank_attr_next;
    logic [ATTR_W-1:0] fill_attr_reg;
    logic              m_tvalid_reg, m_tvalid_next;

    // Payload registers of the request in hand.
    logic [REQ_W-1:0]   req_reg;
    logic [CHAR_W-1:0]  ch_reg;
    logic [ATTR_W-1:0]  attr_reg;
    logic               rd_ok_reg;
    logic [TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Request fields.
    logic [CHAR_W-1:0] in_char;
    logic [ATTR_W-1:0] in_attr;
    logic [RCOL_W-1:0] in_rcol;
    logic [RROW_W-1:0] in_rrow;
    logic              in_range;
    logic              accept;

    // Screen RAM ports.
    logic              ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
    logic [CELL_W-1:0] ram_wr_data, ram_rd_data;

    logic [ADDR_W-1:0] cur_addr;
    logic              finish;
    logic              out_free;
    logic [CHAR_W-1:0] res_char;
    logic [ATTR_W-1:0] res_attr;
    logic              adv_row;

    assign in_char = s_tdata[7:0];
    assign in_attr = s_tdata[15:8];
    assign in_rcol = s_tdata[22:16];
    assign in_rrow = s_tdata[27:23];

    assign in_range = (32'(in_rcol) < COLUMNS) && (32'(in_rrow) < ROWS);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign cur_addr = ADDR_W'(32'(row_reg) * COLUMNS + 32'(col_reg));

    // The read result comes straight from the RAM output, which holds its
    // value until the next read is started.
    assign res_char = (req_reg == REQ_READ && rd_ok_reg) ? ram_rd_data[CHAR_W-1:0] : '0;
    assign res_attr = (req_reg == REQ_READ && rd_ok_reg) ? ram_rd_data[CELL_W-1:CHAR_W] : '0;

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        init_next       = init_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        scr_next        = scr_reg;
        blank_attr_next = blank_attr_reg;
        finish          = 1'b0;
        adv_row         = 1'b0;

        ram_wr_en   = 1'b0;
        ram_wr_addr = cur_addr;
        ram_wr_data = {attr_reg, ch_reg};
        ram_rd_en   = 1'b0;
        ram_rd_addr = ADDR_W'(32'(in_rrow) * COLUMNS + 32'(in_rcol));

        unique case (state_reg)
            ST_IDLE: begin
                // A read of a cell on the screen is started as the word is taken.
                ram_rd_en = accept && (s_tuser == REQ_READ) && in_range;
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                scr_next = 1'b0;
                case (req_reg)
                    REQ_WRITE: begin
                        if (ch_reg == CH_NEWLINE) begin
                            col_next = '0;
                            adv_row  = 1'b1;
                        end else if (ch_reg == CH_BACKSPACE) begin
                            if (col_reg != '0) begin
                                col_next    = col_reg - COL_W'(1);
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = cur_addr - ADDR_W'(1);
                                ram_wr_data = {attr_reg, CH_SPACE};
                            end
                        end else begin
                            ram_wr_en = 1'b1;
                            if (col_reg == COL_W'(COLUMNS - 1)) begin
                                col_next = '0;
                                adv_row  = 1'b1;
                            end else begin
                                col_next = col_reg + COL_W'(1);
                            end
                        end
                        if (adv_row && row_reg == ROW_W'(ROWS - 1)) begin
                            // Past the last row: the cursor stays there and the
                            // screen moves up by one row.
                            scr_next        = 1'b1;
                            blank_attr_next = fill_attr_reg;
                            cnt_next        = '0;
                            state_next      = ST_SCROLL;
                        end else begin
                            if (adv_row) begin
                                row_next = row_reg + ROW_W'(1);
                            end
                            finish = 1'b1;
                        end
                    end
                    REQ_CLEAR: begin
                        col_next        = '0;
                        row_next        = '0;
                        blank_attr_next = fill_attr_reg;
                        cnt_next        = '0;
                        state_next      = ST_BLANK;
                    end
                    default: begin
                        finish = 1'b1;
                    end
                endcase
            end
            ST_SCROLL: begin
                // Read cell cnt+COLUMNS while writing back the cell read in
                // the cycle before to cnt-1.
                ram_rd_en   = (cnt_reg < CNT_W'(COPY_N));
                ram_rd_addr = ADDR_W'(cnt_reg + CNT_W'(COLUMNS));
                ram_wr_en   = (cnt_reg != '0);
                ram_wr_addr = ADDR_W'(cnt_reg - CNT_W'(1));
                ram_wr_data = ram_rd_data;
                if (cnt_reg == CNT_W'(COPY_N)) begin
                    state_next = ST_BLANK;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_BLANK: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = ADDR_W'(cnt_reg);
                ram_wr_data = {blank_attr_reg, CH_SPACE};
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CELLS - 1)) begin
                    if (init_reg) begin
                        init_next  = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            ST_RESP: begin
                finish = 1'b1;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish) begin
            state_next = out_free ? ST_IDLE : ST_RESP;
        end
    end

    // Result word, loaded when the request is done and the output is free.
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (finish && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {3'b000, scr_next, RROW_W'(32'(row_next)),
                             RCOL_W'(32'(col_next)), res_attr, res_char};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_BLANK;
            cnt_reg        <= '0;
            init_reg       <= 1'b1;
            col_reg        <= '0;
            row_reg        <= '0;
            scr_reg        <= 1'b0;
            blank_attr_reg <= FILL_ATTR_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            init_reg       <= init_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            scr_reg        <= scr_next;
            blank_attr_reg <= blank_attr_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (accept) begin
            req_reg   <= s_tuser;
            ch_reg    <= in_char;
            attr_reg  <= in_attr;
            rd_ok_reg <= in_range;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_attr_reg <= FILL_ATTR_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_FILL_ATTR) begin
            fill_attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_FILL_ATTR) ? PDATA_W'(fill_attr_reg) : '0;

    // ------------------------------------------------------------------
    // Screen store.
    // ------------------------------------------------------------------
    tterm_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_no_accept_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        init_reg |-> !s_tready)
        else $error("request word taken during the reset clearing pass");

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_EXEC)
        else $error("accepted word not executed in the next cycle");

    a_copy_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_wr_en && ram_rd_en) |-> ram_wr_addr != ram_rd_addr)
        else $error("screen RAM read and write to the same cell");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(col_reg) < COLUMNS) && (32'(row_reg) < ROWS))
        else $error("cursor outside the screen");

    a_scroll_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCROLL |-> row_reg == ROW_W'(ROWS - 1) && scr_reg)
        else $error("scroll with the cursor off the last row");

endmodule

/* tb/text_terminal_writer_tb.sv */
// ----------------------------------------------------------------------------
// text_terminal_writer_tb: self-checking bench for the text terminal writer
// Streams terminal requests into the block, keeps its own copy of the screen
// and cursor, and checks every result word field by field against that copy.
// A short directed opening is followed by random bursts of text, newlines,
// reads, clears and noise under several fill attributes and idling patterns.
// ----------------------------------------------------------------------------
module text_terminal_writer_tb;
    import tterm_pkg::*;

    localparam int COLUMNS = COLUMNS_DEF;
    localparam int ROWS    = ROWS_DEF;

    // The request type that the block must answer without doing anything.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // A clear or a scroll is the slowest request the block takes. Even if every
    // one of the roughly two thousand words were that slow, and the stalls on
    // both sides doubled it, the run would stay well under the limit, which
    // only catches a hang.
    localparam int CYCLE_LIMIT    = 20_000_000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_REQUESTS = 322;
    // Quiet cycles after the last result, enough to cover a trailing scroll.
    localparam int TAIL_CYCLES    = 2 * COLUMNS * ROWS + 16;
    localparam int REPORT_LIMIT   = 10;

    // One request word, fields as they travel on s_tdata and s_tuser.
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [RROW_W-1:0] read_row;
        logic [RCOL_W-1:0] read_col;
        logic [ATTR_W-1:0] char_attr;
        logic [CHAR_W-1:0] char_code;
    } request_t;

    // One result word, packed in the bit order of m_tdata from bit 0 upwards.
    typedef struct packed {
        logic              scrolled;
        logic [RROW_W-1:0] cursor_row;
        logic [RCOL_W-1:0] cursor_col;
        logic [ATTR_W-1:0] cell_attr;
        logic [CHAR_W-1:0] cell_char;
    } reply_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic               s_tvalid = 1'b0;
    logic               s_tready;
    // tdata from bit 0: char_code, char_attr, read_col, read_row, zero padding.
    logic [TDATA_W-1:0] s_tdata  = '0;
    // tuser from bit 0: req_type.
    logic [REQ_W-1:0]   s_tuser  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // tdata from bit 0: cell_char, cell_attr, cursor_col, cursor_row, scrolled.
    logic [TDATA_W-1:0] m_tdata;

    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    always #5 aclk = ~aclk;

    text_terminal_writer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // Bench state: the screen as the block should hold it, the words still to
    // be sent, and the results still to be seen, oldest first.
    // ------------------------------------------------------------------------
    logic [CELL_W-1:0] screen_model [ROWS][COLUMNS];
    int                cursor_col_model = 0;
    int                cursor_row_model = 0;
    logic [ATTR_W-1:0] fill_attr_model  = FILL_ATTR_RESET;

    request_t request_backlog[$];
    reply_t   predicted_replies[$];
    request_t word_on_bus;
    reply_t   seen_reply;
    reply_t   wanted_reply;

    // Percentages of cycles in which the sender holds back or the receiver
    // stalls; each phase sets its own pair.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    int cycle_count    = 0;
    int error_count    = 0;
    int queued_total   = 0;
    int words_accepted = 0;
    int scroll_count   = 0;
    int clear_count    = 0;
    int read_count     = 0;
    int fill_settings  = 0;

    // Blanks whole rows with spaces in the current fill attribute, as reset,
    // clear and the bottom row of a scroll all do.
    function automatic void blank_rows(int first_row, int last_row);
        int r;
        int c;
        for (r = first_row; r <= last_row; r++) begin
            for (c = 0; c < COLUMNS; c++) begin
                screen_model[r][c] = {fill_attr_model, CH_SPACE};
            end
        end
    endfunction

    // Applies one accepted request to the screen copy and works out the
    // result word that the block must return for it.
    function automatic reply_t terminal_apply(request_t rq);
        reply_t rp;
        int     r;
        int     c;
        rp = '0;
        case (rq.req_type)
            REQ_WRITE: begin
                if (rq.char_code == CH_NEWLINE) begin
                    cursor_col_model = 0;
                    cursor_row_model++;
                end else if (rq.char_code == CH_BACKSPACE) begin
                    // At column zero a backspace leaves everything alone.
                    if (cursor_col_model > 0) begin
                        cursor_col_model--;
                        screen_model[cursor_row_model][cursor_col_model] =
                            {rq.char_attr, CH_SPACE};
                    end
                end else begin
                    screen_model[cursor_row_model][cursor_col_model] =
                        {rq.char_attr, rq.char_code};
                    cursor_col_model++;
                    if (cursor_col_model >= COLUMNS) begin
                        cursor_col_model = 0;
                        cursor_row_model++;
                    end
                end
                // Running off the bottom moves every row up by one.
                if (cursor_row_model >= ROWS) begin
                    for (r = 0; r < ROWS - 1; r++) begin
                        for (c = 0; c < COLUMNS; c++) begin
                            screen_model[r][c] = screen_model[r + 1][c];
                        end
                    end
                    blank_rows(ROWS - 1, ROWS - 1);
                    cursor_row_model = ROWS - 1;
                    rp.scrolled = 1'b1;
                    scroll_count++;
                end
            end
            REQ_CLEAR: begin
                blank_rows(0, ROWS - 1);
                cursor_col_model = 0;
                cursor_row_model = 0;
                clear_count++;
            end
            REQ_READ: begin
                // Cells off the screen read back as zero.
                if (rq.read_col < COLUMNS && rq.read_row < ROWS) begin
                    {rp.cell_attr, rp.cell_char} = screen_model[rq.read_row][rq.read_col];
                end
                read_count++;
            end
            default: begin
            end
        endcase
        rp.cursor_col = cursor_col_model[RCOL_W-1:0];
        rp.cursor_row = cursor_row_model[RROW_W-1:0];
        return rp;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers the next waiting word unless the sender is idling this
    // cycle, holds it until it is taken, and predicts the result on the edge
    // at which the block accepts it.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predicted_replies.push_back(terminal_apply(word_on_bus));
                words_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    word_on_bus = request_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'd0, word_on_bus.read_row, word_on_bus.read_col,
                                 word_on_bus.char_attr, word_on_bus.char_code};
                    s_tuser  <= word_on_bus.req_type;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: stalls at random, and checks each result word taken against the
    // oldest prediction. Only the first few failures are described in full.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen_reply = m_tdata[$bits(reply_t)-1:0];
                if (predicted_replies.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("ERROR: result word %h with no request outstanding", m_tdata);
                    end
                end else begin
                    wanted_reply = predicted_replies.pop_front();
                    if (seen_reply.cell_char  !== wanted_reply.cell_char  ||
                        seen_reply.cell_attr  !== wanted_reply.cell_attr  ||
                        seen_reply.cursor_col !== wanted_reply.cursor_col ||
                        seen_reply.cursor_row !== wanted_reply.cursor_row ||
                        seen_reply.scrolled   !== wanted_reply.scrolled) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT) begin
                            $display("ERROR: char %h/%h attr %h/%h col %0d/%0d row %0d/%0d %s",
                                     seen_reply.cell_char, wanted_reply.cell_char,
                                     seen_reply.cell_attr, wanted_reply.cell_attr,
                                     seen_reply.cursor_col, wanted_reply.cursor_col,
                                     seen_reply.cursor_row, wanted_reply.cursor_row,
                                     $sformatf("scrolled %0d/%0d (got/expected)",
                                               seen_reply.scrolled, wanted_reply.scrolled));
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog on the cycle count, so that a hung block still ends the run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_count, predicted_replies.size());
        $display("text_terminal_writer verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                             input logic [ATTR_W-1:0] attr, input logic [RCOL_W-1:0] col,
                             input logic [RROW_W-1:0] row);
        request_t rq;
        rq.req_type  = kind;
        rq.char_code = ch;
        rq.char_attr = attr;
        rq.read_col  = col;
        rq.read_row  = row;
        request_backlog.push_back(rq);
        queued_total++;
    endtask

    // Waits until every word has gone and every result has come back. The
    // sender therefore pauses with the block drained at each phase boundary.
    // Sampling on the falling edge keeps this clear of the clocked blocks.
    task automatic wait_quiet();
        while (request_backlog.size() != 0 || s_tvalid || predicted_replies.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Register write with a setup and an access phase; the register takes the value
    // at the edge that ends the access phase, when the block has nothing in hand.
    task automatic write_fill_attr(input logic [ATTR_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FILL_ATTR;
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        fill_attr_model = value;
        fill_settings++;
    endtask

    // Queues one burst of related words. Text runs and runs of newlines push
    // the cursor down to the bottom row so that scrolling happens often; reads
    // look back at what was written, with a bias to the bottom row; clears are
    // kept rare because each one blanks the whole screen.
    task automatic queue_burst();
        int                roll;
        int                len;
        int                i;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] run_attr;
        logic [ATTR_W-1:0] attr;
        logic [RCOL_W-1:0] col;
        logic [RROW_W-1:0] row;
        roll = $urandom_range(99);
        if (roll < 45) begin
            len      = ($urandom_range(99) < 15) ? $urandom_range(200, 80) : $urandom_range(40, 1);
            run_attr = 8'($urandom_range(255));
            for (i = 0; i < len; i++) begin
                roll = $urandom_range(99);
                if (roll < 7) begin
                    ch = CH_BACKSPACE;
                end else if (roll < 10) begin
                    ch = CH_NEWLINE;
                end else if (roll < 85) begin
                    ch = 8'($urandom_range(8'h7E, 8'h20));
                end else begin
                    ch = 8'($urandom_range(255));
                end
                attr = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : run_attr;
                queue_req(REQ_WRITE, ch, attr, 7'($urandom_range(127)),
                          5'($urandom_range(31)));
            end
        end else if (roll < 60) begin
            len = $urandom_range(20, 1);
            for (i = 0; i < len; i++) begin
                queue_req(REQ_WRITE, CH_NEWLINE, 8'($urandom_range(255)),
                          7'($urandom_range(127)), 5'($urandom_range(31)));
            end
        end else if (roll < 85) begin
            len = $urandom_range(8, 1);
            for (i = 0; i < len; i++) begin
                roll = $urandom_range(99);
                if (roll < 70) begin
                    col = 7'($urandom_range(COLUMNS - 1));
                    row = 5'($urandom_range(ROWS - 1));
                end else if (roll < 85) begin
                    col = 7'($urandom_range(COLUMNS - 1));
                    row = 5'(ROWS - 1);
                end else begin
                    col = 7'($urandom_range(127));
                    row = 5'($urandom_range(31));
                end
                queue_req(REQ_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          col, row);
            end
        end else if (roll < 88) begin
            queue_req(REQ_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      7'($urandom_range(127)), 5'($urandom_range(31)));
        end else begin
            len = $urandom_range(4, 1);
            for (i = 0; i < len; i++) begin
                queue_req(2'($urandom_range(3)), 8'($urandom_range(255)),
                          8'($urandom_range(255)), 7'($urandom_range(127)),
                          5'($urandom_range(31)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        int                ph;
        int                phase_start;
        logic [ATTR_W-1:0] fill;

        // The block blanks its screen after reset with the reset attribute.
        blank_rows(0, ROWS - 1);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening with the reset fill attribute. The first word waits
        // for the block to finish blanking the screen after reset.
        queue_req(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd0);
        queue_req(REQ_READ, 8'hFF, 8'hFF, 7'd79, 5'd24);
        // Reads just past the right edge, just below the bottom, and far out.
        queue_req(REQ_READ, 8'h00, 8'h00, 7'd80, 5'd0);
        queue_req(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd25);
        queue_req(REQ_READ, 8'hFF, 8'hFF, 7'd127, 5'd31);
        // Backspace with the cursor at column zero must change nothing.
        queue_req(REQ_WRITE, CH_BACKSPACE, 8'hFF, 7'd0, 5'd0);
        queue_req(REQ_WRITE, 8'hFF, 8'hFF, 7'd127, 5'd31);
        queue_req(REQ_WRITE, 8'h00, 8'h00, 7'd0, 5'd0);
        queue_req(REQ_WRITE, 8'h41, 8'h1E, 7'd0, 5'd0);
        // A backspace blanks the cell it steps back onto with its own attribute.
        queue_req(REQ_WRITE, CH_BACKSPACE, 8'h5A, 7'd0, 5'd0);
        queue_req(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd0);
        queue_req(REQ_READ, 8'h00, 8'h00, 7'd1, 5'd0);
        queue_req(REQ_READ, 8'h00, 8'h00, 7'd2, 5'd0);
        // The unused request type answers with the cursor and nothing else.
        queue_req(REQ_UNUSED, 8'hFF, 8'hFF, 7'd127, 5'd31);
        queue_req(REQ_WRITE, CH_NEWLINE, 8'hFF, 7'd0, 5'd0);
        queue_req(REQ_WRITE, 8'h7E, 8'h81, 7'd0, 5'd0);
        queue_req(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd1);
        // A clear homes the cursor and blanks in the fill attribute.
        queue_req(REQ_CLEAR, 8'hFF, 8'hFF, 7'd127, 5'd31);
        queue_req(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd1);
        wait_quiet();

        // Random phases, each setting a fill attribute and one of four idling patterns.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       fill = 8'hFF;
                1:       fill = 8'h00;
                3:       fill = FILL_ATTR_RESET;
                default: fill = 8'($urandom_range(255));
            endcase
            write_fill_attr(fill);
            case (ph % 4)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 49;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 49;
                end
                default: begin
                    sender_idle_pct    = 13;
                    receiver_stall_pct = 13;
                end
            endcase
            phase_start = queued_total;
            while (queued_total - phase_start < PHASE_REQUESTS) begin
                queue_burst();
            end
            wait_quiet();
        end

        // Let any late or spurious result word show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d request words: %0d scrolls, %0d clears, %0d reads,",
                 words_accepted, scroll_count, clear_count, read_count);
        $display("under %0d fill attribute settings, with %0d errors found in %0d cycles.",
                 fill_settings, error_count, cycle_count);
        if (error_count == 0 && predicted_replies.size() == 0) begin
            $display("text_terminal_writer verification clean");
        end else begin
            $display("text_terminal_writer verification failed");
        end
        $finish;
    end

endmodule
